/* rtl/pce_pkg.sv */
// pce_pkg: shared widths, header masks and status codes of the packet checksum engine
// no dependencies; used by the channel interfaces and the top level
package pce_pkg;

  localparam int DataW   = 8;
  localparam int IndexW  = 10;
  localparam int LenW    = 10;
  localparam int StatusW = 3;

  localparam logic [7:0]        ExtMask      = 8'h78;
  localparam logic [2:0]        LenMask      = 3'h7;
  localparam logic [IndexW-1:0] IndexMax     = 10'd1023;
  localparam logic [IndexW-1:0] ExtHeaderLen = 10'd6;

  localparam logic [IndexW-1:0] IdxSum8      = 10'd0;
  localparam logic [IndexW-1:0] IdxMode      = 10'd1;
  localparam logic [IndexW-1:0] IdxWords     = 10'd2;
  localparam logic [IndexW-1:0] IdxSum16Lo   = 10'd4;
  localparam logic [IndexW-1:0] IdxSum16Hi   = 10'd5;

  localparam logic [StatusW-1:0] StatusOk       = 3'd0;
  localparam logic [StatusW-1:0] StatusOverBuf  = 3'd1;
  localparam logic [StatusW-1:0] StatusCount    = 3'd2;
  localparam logic [StatusW-1:0] StatusBadSum8  = 3'd3;
  localparam logic [StatusW-1:0] StatusBadSum16 = 3'd4;

  localparam logic RegGenerateMode = 1'b0;

  typedef struct packed {
    logic [7:0]         sum8;
    logic [15:0]        sum16;
    logic [LenW-1:0]    declared_length;
    logic               extended_packet;
    logic [StatusW-1:0] status;
  } pce_result_t;

endpackage

/* rtl/pce_in_if.sv */
// pce_in_if: input byte channel of the packet checksum engine
// depends on pce_pkg for the byte width
interface pce_in_if import pce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

/* rtl/pce_out_if.sv */
// pce_out_if: result channel of the packet checksum engine
// depends on pce_pkg for the field widths
interface pce_out_if import pce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         sum8;
  logic [15:0]        sum16;
  logic [LenW-1:0]    declared_length;
  logic               extended_packet;
  logic [StatusW-1:0] status;

  modport source (output valid, sum8, sum16, declared_length, extended_packet, status,
                  input ready);
  modport sink   (input valid, sum8, sum16, declared_length, extended_packet, status,
                  output ready);
endinterface

/* rtl/packet_checksum_engine.sv */
// packet_checksum_engine: streaming checksum check/generate over command packet bytes
// depends on pce_pkg, pce_in_if and pce_out_if
//
// Bytes of one packet enter on in_i, byte 0 first, one per cycle unless stalled; the final
// byte carries last_byte and yields one result, valid on out_o from the result register.
// Each byte is held in an input register, then a single pass of adders and compares updates
// the packet state and, on the last byte, loads the result register. A pending result stalls
// input only when a further last byte reaches the processing stage. generate_mode (APB
// offset 0, bit 0) selects checksum generation (1) or checking (0); the user must write it
// only while no packet is in flight, and the block itself does not enforce this.
module packet_checksum_engine import pce_pkg::*; #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pce_in_if.sink      in_i,
  pce_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [LenW:0] BufLimit = (LenW+1)'(BUFFER_BYTES);

  // configuration
  logic gen_mode_q;
  logic cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == RegGenerateMode);
  assign prdata  = cfg_sel ? {31'b0, gen_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      gen_mode_q <= pwdata[0];
    end
  end

  // input register
  logic             s1_valid_q;
  logic [DataW-1:0] s1_data_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             out_valid_q;
  logic             in_take;

  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // packet state
  logic [IndexW-1:0] byte_index_q, byte_index_d;
  logic [7:0]        mode_q, mode_d;
  logic [7:0]        words_q, words_d;
  logic [11:0]       psum8_q, psum8_d;
  logic [15:0]       run16_q, run16_d;
  logic [15:0]       rx16_q, rx16_d;
  logic [7:0]        rx8_q, rx8_d;

  logic              ext;
  logic [4:0]        n8;
  logic [LenW-1:0]   declared;
  logic              add8, add16;
  logic              over;
  logic [15:0]       s16;
  logic [12:0]       total;
  logic [8:0]        fold1;
  logic [8:0]        fold2;
  logic [7:0]        s8;
  logic [IndexW:0]   count;
  logic [StatusW-1:0] status;
  pce_result_t       res_d, res_q;

  always_comb begin
    mode_d  = (byte_index_q == IdxMode)  ? s1_data_q : mode_q;
    words_d = (byte_index_q == IdxWords) ? s1_data_q : words_q;
    rx8_d   = (byte_index_q == IdxSum8)  ? s1_data_q : rx8_q;
    rx16_d  = rx16_q;
    if (byte_index_q == IdxSum16Lo) begin
      rx16_d[7:0] = s1_data_q;
    end
    if (byte_index_q == IdxSum16Hi) begin
      rx16_d[15:8] = s1_data_q;
    end

    ext      = (mode_d & ExtMask) == ExtMask;
    n8       = ext ? 5'(ExtHeaderLen) : 5'd2 + {1'b0, mode_d[2:0] & LenMask, 1'b0};
    declared = ext ? ExtHeaderLen + {1'b0, words_d, 1'b0} : {5'b0, n8};

    add8  = (byte_index_q >= 10'd1) && (byte_index_q < {5'b0, n8}) &&
            !(gen_mode_q && ext &&
              (byte_index_q == IdxSum16Lo || byte_index_q == IdxSum16Hi));
    add16 = ext && (byte_index_q >= ExtHeaderLen) && (byte_index_q < declared);

    psum8_d = add8  ? psum8_q + {4'b0, s1_data_q} : psum8_q;
    run16_d = add16 ? run16_q + {8'b0, s1_data_q} : run16_q;
    byte_index_d = (byte_index_q < IndexMax) ? byte_index_q + 10'd1 : IndexMax;

    over  = {1'b0, declared} > BufLimit;
    s16   = (ext && !over) ? run16_d : 16'd0;
    total = {1'b0, psum8_d};
    if (gen_mode_q && ext) begin
      total = total + {5'b0, s16[7:0]} + {5'b0, s16[15:8]};
    end
    fold1 = {4'b0, total[12:8]} + {1'b0, total[7:0]};
    fold2 = {8'b0, fold1[8]} + {1'b0, fold1[7:0]};
    s8    = fold2[7:0];
    count = {1'b0, byte_index_q} + 11'd1;

    if (over) begin
      status = StatusOverBuf;
    end else if (count != {1'b0, declared}) begin
      status = StatusCount;
    end else if (!gen_mode_q && s8 != rx8_d) begin
      status = StatusBadSum8;
    end else if (!gen_mode_q && ext && s16 != rx16_d) begin
      status = StatusBadSum16;
    end else begin
      status = StatusOk;
    end

    res_d.sum8            = s8;
    res_d.sum16           = s16;
    res_d.declared_length = declared;
    res_d.extended_packet = ext;
    res_d.status          = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      mode_q       <= '0;
      words_q      <= '0;
      psum8_q      <= '0;
      run16_q      <= '0;
      rx16_q       <= '0;
      rx8_q        <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        byte_index_q <= '0;
        mode_q       <= '0;
        words_q      <= '0;
        psum8_q      <= '0;
        run16_q      <= '0;
        rx16_q       <= '0;
        rx8_q        <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        mode_q       <= mode_d;
        words_q      <= words_d;
        psum8_q      <= psum8_d;
        run16_q      <= run16_d;
        rx16_q       <= rx16_d;
        rx8_q        <= rx8_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sum8            = res_q.sum8;
  assign out_o.sum16           = res_q.sum16;
  assign out_o.declared_length = res_q.declared_length;
  assign out_o.extended_packet = res_q.extended_packet;
  assign out_o.status          = res_q.status;

`ifndef SYNTHESIS
  // a finished packet always lands in the result register
  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> out_valid_q)
    else $error("last item did not load result register");

  // packet state restarts after the last item
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> byte_index_q == '0 && psum8_q == '0 && run16_q == '0)
    else $error("packet state not cleared after last item");

  // normal packets carry no 16-bit sum
  a_normal_no_sum16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.extended_packet |-> res_q.sum16 == 16'd0)
    else $error("sum16 nonzero for normal packet");

  // input stalls only behind a held item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("input stalled without pending result");
`endif

endmodule

/* dv/tb_packet_checksum_engine.sv */
// tb_packet_checksum_engine: self-checking bench for the packet checksum engine
// drives byte packets and generate_mode writes, predicts every result with a local tracker
// depends on pce_pkg, pce_in_if, pce_out_if and packet_checksum_engine
module tb_packet_checksum_engine;
  import pce_pkg::*;

  localparam int BufferBytes   = 256;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 6;
  localparam int PhaseItems    = 100;
  localparam logic [2:0] GenModeAddr = 3'({RegGenerateMode, 2'b00});

  class packet_sum_tracker;
    bit         gen_mode;
    int         byte_index;
    logic [7:0] mode_byte;
    logic [7:0] words_byte;
    logic [11:0] part_sum8;
    logic [15:0] run_sum16;
    logic [15:0] rx_sum16;
    logic [7:0]  rx_sum8;
    pce_result_t pending_results[$];
    int          errors;

    function new();
      gen_mode = 1'b0;
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_index = 0;
      mode_byte = '0;
      words_byte = '0;
      part_sum8 = '0;
      run_sum16 = '0;
      rx_sum16 = '0;
      rx_sum8 = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int idx;
      int n8;
      int declared;
      int s16;
      int total;
      int count;
      bit ext;
      bit over;
      pce_result_t r;
      idx = byte_index;
      if (idx == IdxMode) mode_byte = b;
      if (idx == IdxWords) words_byte = b;
      if (idx == IdxSum8) rx_sum8 = b;
      if (idx == IdxSum16Lo) rx_sum16[7:0] = b;
      if (idx == IdxSum16Hi) rx_sum16[15:8] = b;
      ext = (mode_byte & ExtMask) == ExtMask;
      n8 = ext ? int'(ExtHeaderLen) : 2 + 2 * int'(mode_byte[2:0] & LenMask);
      declared = ext ? int'(ExtHeaderLen) + 2 * int'(words_byte) : n8;
      if (idx >= 1 && idx < n8 &&
          !(gen_mode && ext && (idx == IdxSum16Lo || idx == IdxSum16Hi)))
        part_sum8 = part_sum8 + 12'(b);
      if (ext && idx >= ExtHeaderLen && idx < declared) run_sum16 = run_sum16 + 16'(b);
      byte_index = (idx < IndexMax) ? idx + 1 : int'(IndexMax);
      if (!last) return;
      over = declared > BufferBytes;
      s16 = (ext && !over) ? int'(run_sum16) : 0;
      total = int'(part_sum8);
      if (gen_mode && ext) total += (s16 & 255) + (s16 >> 8);
      total = (total >> 8) + (total & 255);
      total = (total >> 8) + (total & 255);
      count = idx + 1;
      r.sum8 = 8'(total);
      r.sum16 = 16'(s16);
      r.declared_length = LenW'(declared);
      r.extended_packet = ext;
      if (over) r.status = StatusOverBuf;
      else if (count != declared) r.status = StatusCount;
      else if (!gen_mode && r.sum8 != rx_sum8) r.status = StatusBadSum8;
      else if (!gen_mode && ext && r.sum16 != rx_sum16) r.status = StatusBadSum16;
      else r.status = StatusOk;
      pending_results.push_back(r);
      clear_packet();
    endfunction

    function void check_field(string name, int want, int seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void match_result(pce_result_t got);
      pce_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no packet pending: sum8 %0d status %0d", got.sum8, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("sum8", want.sum8, got.sum8);
      check_field("sum16", want.sum16, got.sum16);
      check_field("declared_length", want.declared_length, got.declared_length);
      check_field("extended_packet", want.extended_packet, got.extended_packet);
      check_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pce_in_if  in_if ();
  pce_out_if out_if ();

  packet_sum_tracker tracker = new();
  logic [7:0] pkt_q[$];
  bit         in_steady;
  int         idle_cycles;

  packet_checksum_engine #(.BUFFER_BYTES(BufferBytes)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.match_result(pce_result_t'{sum8: out_if.sum8, sum16: out_if.sum16,
                                         declared_length: out_if.declared_length,
                                         extended_packet: out_if.extended_packet,
                                         status: out_if.status});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("packet_checksum_engine: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int run_len;
    int stall_len;
    int r;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      run_len = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_if.ready <= 1'b1;
      repeat (run_len) @(negedge clk_i);
      r = $urandom_range(0, 99);
      stall_len = (r < 70) ? $urandom_range(1, 3) :
                  (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 40);
      out_if.ready <= 1'b0;
      repeat (stall_len) @(negedge clk_i);
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == GenModeAddr) tracker.gen_mode = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_results();
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int r;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_byte(b, last);
    @(negedge clk_i);
    r = $urandom_range(0, 99);
    if (!in_steady && r >= 60) begin
      in_if.valid <= 1'b0;
      if (r < 90) repeat ($urandom_range(1, 3)) @(negedge clk_i);
      else if (r < 98) repeat ($urandom_range(4, 10)) @(negedge clk_i);
      else repeat ($urandom_range(20, 40)) @(negedge clk_i);
    end
  endtask

  task automatic send_packet();
    in_steady = ($urandom_range(0, 3) == 0);
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // well-formed packet with matching checksums; fill < 0 gives random payload
  task automatic build_packet(input bit ext, input logic [7:0] mode_b,
                              input logic [7:0] words_b, input int fill);
    int len;
    int sum;
    logic [15:0] s16;
    len = ext ? 6 + 2 * int'(words_b) : 2 + 2 * int'(mode_b[2:0]);
    pkt_q.delete();
    for (int i = 0; i < len; i++) pkt_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    pkt_q[1] = mode_b;
    if (ext) begin
      pkt_q[2] = words_b;
      s16 = '0;
      for (int i = 6; i < len; i++) s16 = s16 + 16'(pkt_q[i]);
      pkt_q[4] = s16[7:0];
      pkt_q[5] = s16[15:8];
    end
    sum = 0;
    for (int i = 1; i < (ext ? 6 : len); i++) sum += pkt_q[i];
    sum = (sum >> 8) + (sum & 255);
    sum = (sum >> 8) + (sum & 255);
    pkt_q[0] = 8'(sum);
  endtask

  task automatic random_packet();
    int r;
    bit ext;
    logic [7:0] mode_b;
    logic [7:0] words_b;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      pkt_q.delete();
      repeat ($urandom_range(1, 8)) pkt_q.push_back(8'($urandom));
      return;
    end
    ext = $urandom_range(0, 1);
    if (ext) begin
      mode_b = ExtMask | (8'($urandom) & 8'h87);
    end else begin
      do mode_b = 8'($urandom); while ((mode_b & ExtMask) == ExtMask);
    end
    r = $urandom_range(0, 99);
    words_b = (r < 70) ? 8'($urandom_range(0, 8)) :
              (r < 92) ? 8'($urandom_range(9, 125)) : 8'($urandom_range(126, 255));
    build_packet(ext, mode_b, words_b, -1);
    if (ext && words_b > 125) begin
      while (pkt_q.size() > 3 + $urandom_range(0, 17)) void'(pkt_q.pop_back());
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
    end else if (r < 80) begin
      pkt_q[0] = pkt_q[0] ^ 8'($urandom_range(1, 255));
    end else if (r < 88) begin
      if (ext) begin
        pkt_q[4] = pkt_q[4] + 8'd1;
        pkt_q[3] = pkt_q[3] - 8'd1;
      end
    end else if (r < 94) begin
      if (pkt_q.size() > 1) repeat ($urandom_range(1, pkt_q.size() - 1)) void'(pkt_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 4)) pkt_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    int phase_items;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: check mode
    write_reg(GenModeAddr, 32'd0);
    pkt_q = '{8'hFF};
    send_packet();
    build_packet(1'b0, 8'h80, 8'h00, -1);
    send_packet();
    build_packet(1'b1, 8'hFF, 8'h01, 8'hFF);
    send_packet();
    build_packet(1'b0, 8'h00, 8'h00, -1);
    pkt_q[0] = pkt_q[0] ^ 8'h5A;
    send_packet();
    build_packet(1'b0, 8'h00, 8'h00, 8'h00);
    pkt_q.push_back(8'h00);
    send_packet();
    // sum16 wrong while sum8 still matches
    build_packet(1'b1, 8'h78, 8'h00, 8'h10);
    pkt_q[4] = pkt_q[4] + 8'd1;
    pkt_q[3] = pkt_q[3] - 8'd1;
    send_packet();
    in_if.valid <= 1'b0;
    wait_results();

    // directed: generate mode, declared length beyond the buffer
    write_reg(GenModeAddr, 32'd1);
    pkt_q = '{8'h00, 8'h78, 8'hFF};
    send_packet();

    for (int ph = 0; ph < 4; ph++) begin
      in_if.valid <= 1'b0;
      wait_results();
      write_reg(GenModeAddr, 32'(ph % 2));
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        random_packet();
        phase_items += pkt_q.size();
        send_packet();
        if ($urandom_range(0, 14) == 0) begin
          in_if.valid <= 1'b0;
          wait_results();
        end
      end
    end

    in_if.valid <= 1'b0;
    wait_results();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("packet_checksum_engine: match");
    end else begin
      $display("packet_checksum_engine: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pce_pkg.sv
rtl/pce_in_if.sv
rtl/pce_out_if.sv
rtl/packet_checksum_engine.sv
dv/tb_packet_checksum_engine.sv
